[hdl/mat3_pkg.sv]
package mat3_pkg;

    // Default geometry and fixed port widths
    localparam int DIM_DEFAULT        = 3;
    localparam int ELEM_WIDTH_DEFAULT = 16;
    localparam int IN_WIDTH           = 16;
    localparam int VALUE_WIDTH        = 33;
    localparam int PADDR_WIDTH        = 3;
    localparam int PDATA_WIDTH        = 32;

    // Operation codes; the spare code behaves as multiply
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_SUB     = 2'd1;
    localparam logic [1:0] OP_MUL     = 2'd2;
    localparam logic [1:0] OP_MUL_ALT = 2'd3;

    // Register index (word address bit)
    localparam logic REG_OPERATION = 1'b0;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_WAIT
    } state_t;

    // Tag that travels with each memory read down the datapath
    typedef struct packed {
        logic valid;
        logic first;
        logic last_k;
        logic last_cell;
        logic mul;
        logic sub;
    } ctl_t;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic cell_done;
        logic out_free;
    } status_t;

    function automatic logic op_is_mul(input logic [1:0] op);
        return (op == OP_MUL) || (op == OP_MUL_ALT);
    endfunction

endpackage

[hdl/mat3_ram.sv]
module mat3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Simple dual port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/mat3_seq.sv]
module mat3_seq import mat3_pkg::*; #(
    parameter int DIM        = DIM_DEFAULT,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
    localparam int CELLS  = DIM * DIM,
    localparam int ADDR_W = $clog2(CELLS),
    localparam int CNT_W  = $clog2(2 * CELLS),
    localparam int K_W    = $clog2(DIM)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_WIDTH-1:0]   s_element,
    input  logic [1:0]            operation,
    input  status_t               status,
    output ctl_t                  ctl,
    output logic                  a_we,
    output logic                  b_we,
    output logic [ADDR_W-1:0]     a_waddr,
    output logic [ADDR_W-1:0]     b_waddr,
    output logic [ELEM_WIDTH-1:0] wdata,
    output logic [ADDR_W-1:0]     a_raddr,
    output logic [ADDR_W-1:0]     b_raddr
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic              mul_reg, mul_next;
    logic              sub_reg, sub_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [ADDR_W-1:0] kdim_reg, kdim_next;
    logic [K_W-1:0]    col_reg, col_next;
    logic [K_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;

    logic              accept;
    logic              load_last;
    logic              in_first;
    logic              k_last;
    logic              col_last;
    logic              row_last;
    logic              cell_last;
    logic              issue;
    logic [CNT_W-1:0]  b_offset;

    assign accept    = s_valid && s_ready;
    assign load_last = (load_count_reg == CNT_W'(2 * CELLS - 1));
    assign in_first  = (load_count_reg < CNT_W'(CELLS));
    assign k_last    = !mul_reg || (k_reg == K_W'(DIM - 1));
    assign col_last  = (col_reg == K_W'(DIM - 1));
    assign row_last  = (row_reg == K_W'(DIM - 1));
    assign cell_last = col_last && row_last;

    // Element narrowing / widening into storage width
    generate
        if (ELEM_WIDTH <= IN_WIDTH) begin : g_narrow
            assign wdata = s_element[ELEM_WIDTH-1:0];
        end else begin : g_wide
            assign wdata = ELEM_WIDTH'(signed'(s_element));
        end
    endgenerate

    // Load-side write ports
    assign b_offset = load_count_reg - CNT_W'(CELLS);
    assign a_we     = accept && in_first;
    assign b_we     = accept && !in_first;
    assign a_waddr  = load_count_reg[ADDR_W-1:0];
    assign b_waddr  = b_offset[ADDR_W-1:0];

    // Read addresses: row of A against column of B, or the same cell of both
    assign a_raddr = row_base_reg + (mul_reg ? ADDR_W'(k_reg) : ADDR_W'(col_reg));
    assign b_raddr = mul_reg ? (kdim_reg + ADDR_W'(col_reg))
                             : (row_base_reg + ADDR_W'(col_reg));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept && load_last) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (issue && k_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (status.cell_done) begin
                    state_next = cell_last ? ST_LOAD : ST_ISSUE;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // State outputs; a new cell starts only once the output register can take it
    always_comb begin
        s_ready = 1'b0;
        issue   = 1'b0;
        case (state_reg)
            ST_LOAD:  s_ready = 1'b1;
            ST_ISSUE: issue   = (k_reg != '0) || status.out_free;
            ST_WAIT:  issue   = 1'b0;
            default: begin
                s_ready = 1'b0;
                issue   = 1'b0;
            end
        endcase
    end

    assign ctl.valid     = issue;
    assign ctl.first     = (k_reg == '0);
    assign ctl.last_k    = k_last;
    assign ctl.last_cell = cell_last;
    assign ctl.mul       = mul_reg;
    assign ctl.sub       = sub_reg;

    // Counters
    always_comb begin
        load_count_next = load_count_reg;
        mul_next        = mul_reg;
        sub_next        = sub_reg;
        k_next          = k_reg;
        kdim_next       = kdim_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        row_base_next   = row_base_reg;
        if (accept) begin
            if (load_last) begin
                load_count_next = '0;
                mul_next        = op_is_mul(operation);
                sub_next        = (operation == OP_SUB);
                k_next          = '0;
                kdim_next       = '0;
                col_next        = '0;
                row_next        = '0;
                row_base_next   = '0;
            end else begin
                load_count_next = load_count_reg + 1'b1;
            end
        end
        if (issue) begin
            if (k_last) begin
                k_next    = '0;
                kdim_next = '0;
            end else begin
                k_next    = k_reg + 1'b1;
                kdim_next = kdim_reg + ADDR_W'(DIM);
            end
        end
        if ((state_reg == ST_WAIT) && status.cell_done) begin
            if (col_last) begin
                col_next      = '0;
                row_next      = row_last ? '0 : row_reg + 1'b1;
                row_base_next = row_last ? '0 : row_base_reg + ADDR_W'(DIM);
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            mul_reg        <= 1'b0;
            sub_reg        <= 1'b0;
            k_reg          <= '0;
            kdim_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            row_base_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            mul_reg        <= mul_next;
            sub_reg        <= sub_next;
            k_reg          <= k_next;
            kdim_reg       <= kdim_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            row_base_reg   <= row_base_next;
        end
    end

    // Checks
    a_issue_only_in_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (state_reg == ST_ISSUE))
        else $error("read issued outside issue state");

    a_set_starts_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && load_last) |=> (state_reg == ST_ISSUE) && (load_count_reg == '0))
        else $error("completed set did not start compute");

    a_done_while_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        status.cell_done |-> (state_reg == ST_WAIT))
        else $error("cell finished while sequencer not waiting");

endmodule

[hdl/mat3_dp.sv]
module mat3_dp import mat3_pkg::*; #(
    parameter int DIM        = DIM_DEFAULT,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
    localparam int ACC_W = 2 * ELEM_WIDTH + $clog2(DIM)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctl_t                   ctl,
    input  logic [ELEM_WIDTH-1:0]  a_rdata,
    input  logic [ELEM_WIDTH-1:0]  b_rdata,
    output status_t                status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_value,
    output logic                   m_last
);

    ctl_t                      ctl1_reg;
    ctl_t                      ctl2_reg;
    logic signed [ACC_W-1:0]   term_reg, term_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0]    m_value_reg, m_value_next;
    logic                      m_last_reg, m_last_next;
    logic                      m_valid_reg, m_valid_next;

    logic signed [ELEM_WIDTH-1:0]   a_s;
    logic signed [ELEM_WIDTH-1:0]   b_s;
    logic signed [2*ELEM_WIDTH-1:0] prod;
    logic signed [ACC_W-1:0]        sum;
    logic [VALUE_WIDTH-1:0]         sum_value;
    logic                           cell_done;

    assign a_s = a_rdata;
    assign b_s = b_rdata;

    // Stage 2: product or element-wise sum/difference
    always_comb begin
        prod = a_s * b_s;
        if (ctl1_reg.mul) begin
            term_next = ACC_W'(prod);
        end else if (ctl1_reg.sub) begin
            term_next = ACC_W'(a_s) - ACC_W'(b_s);
        end else begin
            term_next = ACC_W'(a_s) + ACC_W'(b_s);
        end
    end

    // Stage 3: accumulate, hand the finished cell to the output register
    assign sum       = (ctl2_reg.first ? '0 : acc_reg) + term_reg;
    assign cell_done = ctl2_reg.valid && ctl2_reg.last_k;

    generate
        if (ACC_W >= VALUE_WIDTH) begin : g_wrap
            assign sum_value = sum[VALUE_WIDTH-1:0];
        end else begin : g_extend
            assign sum_value = VALUE_WIDTH'(sum);
        end
    endgenerate

    always_comb begin
        acc_next     = acc_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (ctl2_reg.valid) begin
            acc_next = sum;
        end
        if (cell_done) begin
            m_value_next = sum_value;
            m_last_next  = ctl2_reg.last_cell;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg    <= '0;
            ctl2_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ctl1_reg    <= ctl;
            ctl2_reg    <= ctl1_reg;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        term_reg    <= term_next;
        acc_reg     <= acc_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign status.cell_done = cell_done;
    assign status.out_free  = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_value          = m_value_reg;
    assign m_last           = m_last_reg;

    // Checks
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_done |-> (!m_valid_reg || m_ready))
        else $error("result written over a pending transaction");

    a_valid_from_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cell_done))
        else $error("output valid without a finished cell");

    a_contiguous_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl2_reg.valid && !ctl2_reg.first) |-> $past(ctl2_reg.valid && !ctl2_reg.last_k))
        else $error("accumulation term out of sequence");

endmodule

[hdl/matrix3x3_add_sub_mul.sv]
// Streaming DIM x DIM matrix add / subtract / multiply, operands held in two RAMs.
// Load: one element per cycle, 2*DIM*DIM elements per set; no input is taken while results are computed.
// Compute: one RAM read pair per cycle while issuing; each cell passes the read, product and
// accumulate stages, and the next cell's reads wait until that cell is done and the output
// register is free. The default set is 18 elements.
// Reset (aresetn, synchronous, active low) clears the load count, sequencer and operation.
module matrix3x3_add_sub_mul import mat3_pkg::*; #(
    parameter int DIM        = DIM_DEFAULT,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
    localparam int CELLS  = DIM * DIM,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [PDATA_WIDTH-1:0] pwdata,
    output logic [PDATA_WIDTH-1:0] prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [IN_WIDTH-1:0]    s_element,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_value,
    output logic                   m_last
);

    logic [1:0]            operation_reg, operation_next;
    logic                  reg_index;
    logic                  cfg_write;

    status_t               status;
    ctl_t                  ctl;
    logic                  a_we, b_we;
    logic [ADDR_W-1:0]     a_waddr, b_waddr;
    logic [ADDR_W-1:0]     a_raddr, b_raddr;
    logic [ELEM_WIDTH-1:0] wdata;
    logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;

    // Config port
    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_WIDTH-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        operation_next = operation_reg;
        if (cfg_write && (reg_index == REG_OPERATION)) begin
            operation_next = pwdata[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operation_reg <= OP_ADD;
        end else begin
            operation_reg <= operation_next;
        end
    end

    assign prdata = (reg_index == REG_OPERATION) ? PDATA_WIDTH'(operation_reg) : '0;

    mat3_seq #(
        .DIM        (DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_element (s_element),
        .operation (operation_reg),
        .status    (status),
        .ctl       (ctl),
        .a_we      (a_we),
        .b_we      (b_we),
        .a_waddr   (a_waddr),
        .b_waddr   (b_waddr),
        .wdata     (wdata),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr)
    );

    // Operand stores
    mat3_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CELLS)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (a_we),
        .wr_addr (a_waddr),
        .wr_data (wdata),
        .rd_addr (a_raddr),
        .rd_data (a_rdata)
    );

    mat3_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CELLS)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (wdata),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    mat3_dp #(
        .DIM        (DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value),
        .m_last  (m_last)
    );

endmodule
